>>> hw/rtl/v3a_pkg.sv
// Shared types, widths and helper functions for the vector3_alu block.
// Used by every module of the block; depends on nothing else.

package v3a_pkg;

    // Fraction bits of the signed fixed-point format (Q16.16 at 16).
    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int PROD_W    = 2 * W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int MAG_W     = W + FRAC_BITS;
    localparam int NUM_W     = MAG_W + 1;
    localparam int DIV_W     = W + 1;
    localparam int SQ_STEPS  = W;
    // Input register, product stage, root steps, divisor stage, divider steps, output.
    localparam int LATENCY   = SQ_STEPS + NUM_W + 4;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX  = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN  = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_SCALE,
        OP_DIV,
        OP_DOT,
        OP_CROSS,
        OP_NORM,
        OP_NORMALIZE
    } op_t;

    typedef struct packed {
        logic         ovf;
        logic [W-1:0] val;
    } sat_t;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic [W-1:0]     r;
        logic             ovf;
        logic [MAG_W-1:0] mag;
        logic             neg;
    } lane_t;

    // Per-request sideband that travels alongside the root and divider pipelines.
    typedef struct packed {
        op_t               op;
        logic [2:0][W-1:0] vec;
        logic [W-1:0]      scal;
        logic              ovf;
        logic              dz;
        logic [2:0]        neg;
    } side_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
        sat_t s;
        if (v > ACC_MAX) begin
            s.ovf = 1'b1;
            s.val = {1'b0, {(W-1){1'b1}}};
        end else if (v < ACC_MIN) begin
            s.ovf = 1'b1;
            s.val = {1'b1, {(W-1){1'b0}}};
        end else begin
            s.ovf = 1'b0;
            s.val = v[W-1:0];
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/vector3_alu.sv
// Top level of the three-component fixed-point vector unit.
// Depends on v3a_pkg, v3a_lane, v3a_merge and v3a_div.
//
// Usage: drive cmd, the vectors a and b and factor, and raise start. A request
// is taken at every rising edge where start is high and busy is low. busy
// never rises: the block is a fully pipelined datapath and takes one request
// per clock cycle, back to back, with any number of requests in flight.
// Each request gives exactly one result. It is shown on r_x, r_y, r_z,
// r_scalar, overflow and div_zero for a single cycle while done is high, and
// results leave in the order the requests came in. The receiver cannot hold
// a result off, so it must capture it in the cycle that done marks.
// A request runs through the input register, the product stage, the 32
// pipelined steps of the square root, the divisor stage, the 33 + FRAC_BITS
// steps of the per-lane dividers (FRAC_BITS is 16 for Q16.16) and the output
// register; every opcode travels the same path so results never reorder.
// Reset clears every valid flag at once; the datapath registers are left
// alone, and requests can be issued in the first cycle after reset.

module vector3_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    cmd,
    input  logic signed [v3a_pkg::W-1:0]  a_x,
    input  logic signed [v3a_pkg::W-1:0]  a_y,
    input  logic signed [v3a_pkg::W-1:0]  a_z,
    input  logic signed [v3a_pkg::W-1:0]  b_x,
    input  logic signed [v3a_pkg::W-1:0]  b_y,
    input  logic signed [v3a_pkg::W-1:0]  b_z,
    input  logic signed [v3a_pkg::W-1:0]  factor,
    output logic                          done,
    output logic signed [v3a_pkg::W-1:0]  r_x,
    output logic signed [v3a_pkg::W-1:0]  r_y,
    output logic signed [v3a_pkg::W-1:0]  r_z,
    output logic signed [v3a_pkg::W-1:0]  r_scalar,
    output logic                          overflow,
    output logic                          div_zero
);

    localparam logic [v3a_pkg::NUM_W-1:0] QMAX =
        {{(v3a_pkg::NUM_W-v3a_pkg::W+1){1'b0}}, {(v3a_pkg::W-1){1'b1}}};
    localparam logic [v3a_pkg::NUM_W-1:0] QMIN = QMAX + 1'b1;

    // Clamp a rounded quotient magnitude with its sign into the result range.
    function automatic v3a_pkg::sat_t sat_quot(input logic [v3a_pkg::NUM_W-1:0] q,
                                               input logic neg);
        v3a_pkg::sat_t s;
        if (!neg)
        begin
            if (q > QMAX)
            begin
                s.ovf = 1'b1;
                s.val = {1'b0, {(v3a_pkg::W-1){1'b1}}};
            end
            else
            begin
                s.ovf = 1'b0;
                s.val = q[v3a_pkg::W-1:0];
            end
        end
        else
        begin
            if (q > QMIN)
            begin
                s.ovf = 1'b1;
                s.val = {1'b1, {(v3a_pkg::W-1){1'b0}}};
            end
            else
            begin
                s.ovf = 1'b0;
                s.val = '0 - q[v3a_pkg::W-1:0];
            end
        end
        return s;
    endfunction

    logic                                 accept;
    v3a_pkg::op_t                         op_in;
    logic                                 v1_reg;
    v3a_pkg::op_t                         op1_reg;
    logic signed [v3a_pkg::W-1:0]         f1_reg;

    logic [2:0][v3a_pkg::PROD_W-1:0]      prod;
    v3a_pkg::lane_t [2:0]                 lane;

    logic                                 mg_valid;
    v3a_pkg::side_t                       mg_side;
    logic [v3a_pkg::DIV_W-1:0]            mg_div;
    logic [2:0][v3a_pkg::NUM_W-1:0]       mg_num;
    logic [2:0][v3a_pkg::NUM_W-1:0]       quot;

    logic                                 dl_valid_reg [v3a_pkg::NUM_W];
    v3a_pkg::side_t                       dl_side_reg  [v3a_pkg::NUM_W];

    v3a_pkg::side_t                       fin_side;
    logic                                 fin_div;
    v3a_pkg::sat_t [2:0]                  qsat;
    logic [2:0][v3a_pkg::W-1:0]           vec_next;
    logic                                 ovf_next;

    logic                                 done_reg;
    logic [2:0][v3a_pkg::W-1:0]           vec_reg;
    logic [v3a_pkg::W-1:0]                scal_reg;
    logic                                 overflow_reg;
    logic                                 div_zero_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op_in  = v3a_pkg::op_t'(cmd);

    // Request register for the control fields the merge stage needs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= op_in;
        f1_reg  <= factor;
    end

    // Three lanes, one per component; the cross product takes the other two.
    v3a_lane u_lane_x (
        .clk    (clk),
        .op     (op_in),
        .a_self (a_x),
        .b_self (b_x),
        .a_next (a_y),
        .b_next (b_y),
        .a_prev (a_z),
        .b_prev (b_z),
        .factor (factor),
        .prod   (prod[0]),
        .res    (lane[0])
    );

    v3a_lane u_lane_y (
        .clk    (clk),
        .op     (op_in),
        .a_self (a_y),
        .b_self (b_y),
        .a_next (a_z),
        .b_next (b_z),
        .a_prev (a_x),
        .b_prev (b_x),
        .factor (factor),
        .prod   (prod[1]),
        .res    (lane[1])
    );

    v3a_lane u_lane_z (
        .clk    (clk),
        .op     (op_in),
        .a_self (a_z),
        .b_self (b_z),
        .a_next (a_x),
        .b_next (b_x),
        .a_prev (a_y),
        .b_prev (b_y),
        .factor (factor),
        .prod   (prod[2]),
        .res    (lane[2])
    );

    // Dot product, sum of squares, square root and divisor selection.
    v3a_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .op        (op1_reg),
        .factor    (f1_reg),
        .prod      (prod),
        .lane      (lane),
        .out_valid (mg_valid),
        .side      (mg_side),
        .divisor   (mg_div),
        .num       (mg_num)
    );

    // One divider per lane, all sharing the merged divisor.
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        v3a_div u_div (
            .clk     (clk),
            .num     (mg_num[g]),
            .divisor (mg_div),
            .quot    (quot[g])
        );
    end

    // Sideband delay line matching the divider depth.
    for (genvar k = 0; k < v3a_pkg::NUM_W; k++)
    begin : g_dl
        logic           valid_in;
        v3a_pkg::side_t side_in;

        if (k == 0)
        begin : g_first
            assign valid_in = mg_valid;
            assign side_in  = mg_side;
        end
        else
        begin : g_rest
            assign valid_in = dl_valid_reg[k-1];
            assign side_in  = dl_side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dl_valid_reg[k] <= 1'b0;
            end
            else
            begin
                dl_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dl_side_reg[k] <= side_in;
        end
    end

    // Final selection: quotients for divide and normalize, lane results otherwise.
    // A zero divisor or a zero-length vector forces every field to zero.
    always_comb
    begin
        fin_side = dl_side_reg[v3a_pkg::NUM_W-1];
        fin_div  = (fin_side.op == v3a_pkg::OP_DIV) ||
                   (fin_side.op == v3a_pkg::OP_NORMALIZE);
        ovf_next = fin_side.ovf;
        for (int i = 0; i < 3; i++)
        begin
            qsat[i] = sat_quot(quot[i], fin_side.neg[i]);
            if (!fin_div)
            begin
                vec_next[i] = fin_side.vec[i];
            end
            else if (fin_side.dz)
            begin
                vec_next[i] = '0;
            end
            else
            begin
                vec_next[i] = qsat[i].val;
                ovf_next    = ovf_next | qsat[i].ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dl_valid_reg[v3a_pkg::NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg      <= vec_next;
        scal_reg     <= fin_side.scal;
        overflow_reg <= ovf_next;
        div_zero_reg <= fin_side.dz;
    end

    assign done     = done_reg;
    assign r_x      = vec_reg[0];
    assign r_y      = vec_reg[1];
    assign r_z      = vec_reg[2];
    assign r_scalar = scal_reg;
    assign overflow = overflow_reg;
    assign div_zero = div_zero_reg;

endmodule

>>> hw/rtl/v3a_lane.sv
// One component lane: two multipliers, add/sub, rounding and clamping.
// Depends on v3a_pkg.

module v3a_lane (
    input  logic                               clk,
    input  v3a_pkg::op_t                       op,
    input  logic signed [v3a_pkg::W-1:0]       a_self,
    input  logic signed [v3a_pkg::W-1:0]       b_self,
    input  logic signed [v3a_pkg::W-1:0]       a_next,
    input  logic signed [v3a_pkg::W-1:0]       b_next,
    input  logic signed [v3a_pkg::W-1:0]       a_prev,
    input  logic signed [v3a_pkg::W-1:0]       b_prev,
    input  logic signed [v3a_pkg::W-1:0]       factor,
    output logic signed [v3a_pkg::PROD_W-1:0]  prod,
    output v3a_pkg::lane_t                     res
);

    logic signed [v3a_pkg::W-1:0]      mul_x;
    logic signed [v3a_pkg::W-1:0]      mul_y;
    logic signed [v3a_pkg::PROD_W-1:0] prod_next;
    logic signed [v3a_pkg::PROD_W-1:0] prod_reg;
    logic signed [v3a_pkg::PROD_W-1:0] cross_next;
    logic signed [v3a_pkg::PROD_W-1:0] cross_reg;
    logic signed [v3a_pkg::W-1:0]      a_reg;
    logic signed [v3a_pkg::W-1:0]      b_reg;
    logic                              fneg_reg;
    v3a_pkg::op_t                      op_reg;

    logic signed [v3a_pkg::ACC_W-1:0]  wide_a;
    logic signed [v3a_pkg::ACC_W-1:0]  wide_b;
    logic signed [v3a_pkg::ACC_W-1:0]  wide_p;
    logic signed [v3a_pkg::ACC_W-1:0]  wide_c;
    logic signed [v3a_pkg::ACC_W-1:0]  sum;
    logic [v3a_pkg::W-1:0]             a_abs;
    v3a_pkg::sat_t                     sat;
    v3a_pkg::lane_t                    res_next;
    v3a_pkg::lane_t                    res_reg;

    // Operand select: the main multiplier serves scale, dot, norm, normalize and one cross term.
    always_comb
    begin
        mul_x = a_self;
        mul_y = '0;
        case (op)
            v3a_pkg::OP_SCALE:     mul_y = factor;
            v3a_pkg::OP_DOT:       mul_y = b_self;
            v3a_pkg::OP_CROSS:
            begin
                mul_x = a_next;
                mul_y = b_prev;
            end
            v3a_pkg::OP_NORM:      mul_y = a_self;
            v3a_pkg::OP_NORMALIZE: mul_y = a_self;
            default:               mul_y = '0;
        endcase
    end

    assign prod_next  = mul_x * mul_y;
    assign cross_next = a_prev * b_next;

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        cross_reg <= cross_next;
        a_reg     <= a_self;
        b_reg     <= b_self;
        fneg_reg  <= factor[v3a_pkg::W-1];
        op_reg    <= op;
    end

    always_comb
    begin
        wide_a = {{(v3a_pkg::ACC_W-v3a_pkg::W){a_reg[v3a_pkg::W-1]}}, a_reg};
        wide_b = {{(v3a_pkg::ACC_W-v3a_pkg::W){b_reg[v3a_pkg::W-1]}}, b_reg};
        wide_p = {{(v3a_pkg::ACC_W-v3a_pkg::PROD_W){prod_reg[v3a_pkg::PROD_W-1]}}, prod_reg};
        wide_c = {{(v3a_pkg::ACC_W-v3a_pkg::PROD_W){cross_reg[v3a_pkg::PROD_W-1]}},
                  cross_reg};
        case (op_reg)
            v3a_pkg::OP_ADD:   sum = wide_a + wide_b;
            v3a_pkg::OP_SUB:   sum = wide_a - wide_b;
            v3a_pkg::OP_SCALE: sum = (wide_p + v3a_pkg::ACC_HALF) >>> v3a_pkg::FRAC_BITS;
            v3a_pkg::OP_CROSS:
                sum = (wide_p - wide_c + v3a_pkg::ACC_HALF) >>> v3a_pkg::FRAC_BITS;
            default:           sum = '0;
        endcase
        sat   = v3a_pkg::sat_acc(sum);
        a_abs = a_reg[v3a_pkg::W-1] ? ('0 - a_reg) : a_reg;

        res_next.r   = sat.val;
        res_next.ovf = sat.ovf;
        res_next.mag = {a_abs, {v3a_pkg::FRAC_BITS{1'b0}}};
        res_next.neg = (op_reg == v3a_pkg::OP_DIV) ? (a_reg[v3a_pkg::W-1] ^ fneg_reg)
                                                   : a_reg[v3a_pkg::W-1];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign prod = prod_reg;
    assign res  = res_reg;

endmodule

>>> hw/rtl/v3a_merge.sv
// Merge stage: sums the lane products (dot product, sum of squares), runs the
// pipelined square root and selects the divisor. Depends on v3a_pkg.

module v3a_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  v3a_pkg::op_t                          op,
    input  logic signed [v3a_pkg::W-1:0]          factor,
    input  logic [2:0][v3a_pkg::PROD_W-1:0]       prod,
    input  v3a_pkg::lane_t [2:0]                  lane,
    output logic                                  out_valid,
    output v3a_pkg::side_t                        side,
    output logic [v3a_pkg::DIV_W-1:0]             divisor,
    output logic [2:0][v3a_pkg::NUM_W-1:0]        num
);

    localparam int L = v3a_pkg::SQ_STEPS - 1;

    logic signed [v3a_pkg::ACC_W-1:0] ext [3];
    logic signed [v3a_pkg::ACC_W-1:0] dot_sum;
    v3a_pkg::sat_t                    dot_next;
    logic [v3a_pkg::PROD_W-1:0]       sq_next;
    logic [v3a_pkg::W-1:0]            f_abs;

    logic                             v2_reg;
    v3a_pkg::op_t                     op2_reg;
    v3a_pkg::sat_t                    dot2_reg;
    logic [v3a_pkg::PROD_W-1:0]       sq2_reg;
    logic [v3a_pkg::DIV_W-1:0]        absf2_reg;
    logic                             fzero2_reg;

    v3a_pkg::side_t                   side0;
    logic [2:0][v3a_pkg::MAG_W-1:0]   mag0;

    logic                             sq_valid_reg [v3a_pkg::SQ_STEPS];
    v3a_pkg::side_t                   sq_side_reg  [v3a_pkg::SQ_STEPS];
    logic [2:0][v3a_pkg::MAG_W-1:0]   sq_mag_reg   [v3a_pkg::SQ_STEPS];
    logic [v3a_pkg::DIV_W-1:0]        sq_absf_reg  [v3a_pkg::SQ_STEPS];
    logic [v3a_pkg::PROD_W-1:0]       sq_rem_reg   [v3a_pkg::SQ_STEPS];
    logic [v3a_pkg::PROD_W-1:0]       sq_root_reg  [v3a_pkg::SQ_STEPS];

    logic [v3a_pkg::PROD_W-1:0]       root_fin;
    logic [v3a_pkg::DIV_W-1:0]        len;
    logic signed [v3a_pkg::ACC_W-1:0] len_wide;
    v3a_pkg::sat_t                    len_sat;
    v3a_pkg::side_t                   side_next;
    logic [v3a_pkg::DIV_W-1:0]        div_next;
    logic [2:0][v3a_pkg::NUM_W-1:0]   num_next;

    logic                             out_valid_reg;
    v3a_pkg::side_t                   side_reg;
    logic [v3a_pkg::DIV_W-1:0]        div_reg;
    logic [2:0][v3a_pkg::NUM_W-1:0]   num_reg;

    // Product sums; both are formed, the opcode decides which one matters.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ext[i] = {{(v3a_pkg::ACC_W-v3a_pkg::PROD_W){prod[i][v3a_pkg::PROD_W-1]}},
                      prod[i]};
        end
        dot_sum  = (ext[0] + ext[1] + ext[2] + v3a_pkg::ACC_HALF) >>> v3a_pkg::FRAC_BITS;
        dot_next = v3a_pkg::sat_acc(dot_sum);
        sq_next  = prod[0] + prod[1] + prod[2];
        f_abs    = factor[v3a_pkg::W-1] ? ('0 - factor) : factor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op2_reg    <= op;
        dot2_reg   <= dot_next;
        sq2_reg    <= sq_next;
        absf2_reg  <= {1'b0, f_abs};
        fzero2_reg <= (factor == '0);
    end

    always_comb
    begin
        side0.op   = op2_reg;
        side0.ovf  = (op2_reg == v3a_pkg::OP_DOT) && dot2_reg.ovf;
        side0.scal = (op2_reg == v3a_pkg::OP_DOT) ? dot2_reg.val : '0;
        side0.dz   = ((op2_reg == v3a_pkg::OP_DIV) && fzero2_reg) ||
                     ((op2_reg == v3a_pkg::OP_NORMALIZE) && (sq2_reg == '0));
        for (int i = 0; i < 3; i++)
        begin
            side0.vec[i] = lane[i].r;
            side0.neg[i] = lane[i].neg;
            side0.ovf    = side0.ovf | lane[i].ovf;
            mag0[i]      = lane[i].mag;
        end
    end

    // One digit of the restoring square root per stage.
    for (genvar k = 0; k < v3a_pkg::SQ_STEPS; k++)
    begin : g_sq
        localparam logic [v3a_pkg::PROD_W-1:0] STEP_BIT =
            {{(v3a_pkg::PROD_W-1){1'b0}}, 1'b1} << (v3a_pkg::PROD_W - 2 - 2 * k);

        logic                           valid_in;
        v3a_pkg::side_t                 side_in;
        logic [2:0][v3a_pkg::MAG_W-1:0] mag_in;
        logic [v3a_pkg::DIV_W-1:0]      absf_in;
        logic [v3a_pkg::PROD_W-1:0]     rem_in;
        logic [v3a_pkg::PROD_W-1:0]     root_in;
        logic [v3a_pkg::PROD_W-1:0]     trial;
        logic                           take;
        logic [v3a_pkg::PROD_W-1:0]     rem_next;
        logic [v3a_pkg::PROD_W-1:0]     root_next;

        if (k == 0)
        begin : g_first
            assign valid_in = v2_reg;
            assign side_in  = side0;
            assign mag_in   = mag0;
            assign absf_in  = absf2_reg;
            assign rem_in   = sq2_reg;
            assign root_in  = '0;
        end
        else
        begin : g_rest
            assign valid_in = sq_valid_reg[k-1];
            assign side_in  = sq_side_reg[k-1];
            assign mag_in   = sq_mag_reg[k-1];
            assign absf_in  = sq_absf_reg[k-1];
            assign rem_in   = sq_rem_reg[k-1];
            assign root_in  = sq_root_reg[k-1];
        end

        assign trial     = root_in + STEP_BIT;
        assign take      = (rem_in >= trial);
        assign rem_next  = take ? (rem_in - trial) : rem_in;
        assign root_next = take ? ((root_in >> 1) + STEP_BIT) : (root_in >> 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_side_reg[k] <= side_in;
            sq_mag_reg[k]  <= mag_in;
            sq_absf_reg[k] <= absf_in;
            sq_rem_reg[k]  <= rem_next;
            sq_root_reg[k] <= root_next;
        end
    end

    // Round the root, finish the norm and set up the divisions.
    always_comb
    begin
        root_fin  = sq_root_reg[L] +
                    {{(v3a_pkg::PROD_W-1){1'b0}}, (sq_rem_reg[L] > sq_root_reg[L])};
        len       = root_fin[v3a_pkg::DIV_W-1:0];
        len_wide  = {{(v3a_pkg::ACC_W-v3a_pkg::DIV_W){1'b0}}, len};
        len_sat   = v3a_pkg::sat_acc(len_wide);
        side_next = sq_side_reg[L];
        if (side_next.op == v3a_pkg::OP_NORM)
        begin
            side_next.scal = len_sat.val;
            side_next.ovf  = side_next.ovf | len_sat.ovf;
        end
        div_next = (side_next.op == v3a_pkg::OP_NORMALIZE) ? len : sq_absf_reg[L];
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = {1'b0, sq_mag_reg[L][i]} +
                          {{(v3a_pkg::NUM_W-v3a_pkg::DIV_W+1){1'b0}},
                           div_next[v3a_pkg::DIV_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= sq_valid_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        div_reg  <= div_next;
        num_reg  <= num_next;
    end

    assign out_valid = out_valid_reg;
    assign side      = side_reg;
    assign divisor   = div_reg;
    assign num       = num_reg;

endmodule

>>> hw/rtl/v3a_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on v3a_pkg.

module v3a_div (
    input  logic                        clk,
    input  logic [v3a_pkg::NUM_W-1:0]   num,
    input  logic [v3a_pkg::DIV_W-1:0]   divisor,
    output logic [v3a_pkg::NUM_W-1:0]   quot
);

    logic [v3a_pkg::DIV_W-1:0] rem_reg [v3a_pkg::NUM_W];
    logic [v3a_pkg::NUM_W-1:0] nq_reg  [v3a_pkg::NUM_W];
    logic [v3a_pkg::DIV_W-1:0] dv_reg  [v3a_pkg::NUM_W];

    // The numerator shifts out at the top while quotient bits shift in below.
    for (genvar k = 0; k < v3a_pkg::NUM_W; k++)
    begin : g_step
        logic [v3a_pkg::DIV_W-1:0] rem_in;
        logic [v3a_pkg::NUM_W-1:0] nq_in;
        logic [v3a_pkg::DIV_W-1:0] dv_in;
        logic [v3a_pkg::DIV_W:0]   trial;
        logic [v3a_pkg::DIV_W:0]   diff;
        logic                      take;
        logic [v3a_pkg::DIV_W-1:0] rem_next;
        logic [v3a_pkg::NUM_W-1:0] nq_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign dv_in  = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign dv_in  = dv_reg[k-1];
        end

        assign trial    = {rem_in, nq_in[v3a_pkg::NUM_W-1]};
        assign diff     = trial - {1'b0, dv_in};
        assign take     = (trial >= {1'b0, dv_in});
        assign rem_next = take ? diff[v3a_pkg::DIV_W-1:0] : trial[v3a_pkg::DIV_W-1:0];
        assign nq_next  = {nq_in[v3a_pkg::NUM_W-2:0], take};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            nq_reg[k]  <= nq_next;
            dv_reg[k]  <= dv_in;
        end
    end

    assign quot = nq_reg[v3a_pkg::NUM_W-1];

endmodule

>>> hw/rtl/v3a_checker.sv
// Port-level checker for vector3_alu, attached to the top level by bind.
// Depends on v3a_pkg and vector3_alu.

module v3a_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [v3a_pkg::W-1:0]  r_x,
    input logic signed [v3a_pkg::W-1:0]  r_y,
    input logic signed [v3a_pkg::W-1:0]  r_z,
    input logic signed [v3a_pkg::W-1:0]  r_scalar,
    input logic                          overflow,
    input logic                          div_zero
);

    // Every accepted request produces its result after the fixed latency.
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(v3a_pkg::LATENCY) done)
        else $error("request without result after fixed latency");

    // No result appears without a request at the matching earlier edge.
    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, v3a_pkg::LATENCY))
        else $error("result without matching request");

    // A zero divisor clears every result field.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_zero) |-> (r_x == '0 && r_y == '0 && r_z == '0 && r_scalar == '0))
        else $error("divide-by-zero result is not all zero");

    // A zero divisor never reports saturation.
    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_zero) |-> !overflow)
        else $error("overflow raised together with divide by zero");

endmodule

bind vector3_alu v3a_checker u_v3a_checker (.*);
